[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL; they compile to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/mspc_pkg.sv]
// Types and constants of the motor speed PID controller.
package mspc_pkg;

   localparam logic [15:0] PULSES_PER_REV = 16'd256;

   typedef logic signed [31:0] pulse_type;
   typedef logic signed [8:0]  duty_type;
   typedef logic signed [23:0] speed_type;
   typedef logic [4:0]         paddr_type;
   typedef logic [31:0]        word_type;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_TARGET   = 3'd0;
   localparam logic [2:0] REG_KP       = 3'd1;
   localparam logic [2:0] REG_KI       = 3'd2;
   localparam logic [2:0] REG_KD       = 3'd3;
   localparam logic [2:0] REG_FF       = 3'd4;
   localparam logic [2:0] REG_INTERVAL = 3'd5;

   localparam logic [15:0] INTERVAL_RESET = 16'd20;
   localparam int          GLITCH_LIMIT   = 1000;
   // 1000 ms per second times 2^16 for the Q16 result.
   localparam logic [25:0] SPEED_SCALE    = 26'd65536000;
   localparam int          INTEG_LIMIT    = 65536000;
   localparam int          DEADBAND       = 30;
   localparam int          DUTY_MAX       = 255;

   // Shared restoring divider.
   localparam int DIV_W        = 64;
   localparam int SPD_STEPS    = 36;
   localparam int DERIV_STEPS  = 57;
   localparam int CNT_W        = 6;

endpackage

[hw/rtl/motor_speed_pid_controller.sv]
// Motor speed PID controller with feedforward: one shared multiplier and divider.
//
// Each request carries the cumulative encoder pulse count of one control tick.
// A pulse delta above 1000 in magnitude is a glitch: the count is stored, no
// response is sent, and the block is ready again in the next cycle. In a normal
// tick the bit-serial divider forms the speed, a single 24x28 signed multiplier
// forms the integral, feedforward, proportional, integral and derivative
// products in turn, and the divider forms the derivative term scaled by
// 1000/interval. The divider retires one quotient bit per cycle. req_stall is
// high while a tick is in work. The response register decouples the output,
// so a new request is taken while a finished response still waits. Registers
// must be written through the APB-style port only while idle; the block does
// not enforce this. An interval of zero is treated as one.
module motor_speed_pid_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mspc_pkg::pulse_type req_pulse_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mspc_pkg::duty_type  rsp_drive_duty,
   output mspc_pkg::speed_type rsp_measured_speed,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  mspc_pkg::paddr_type paddr,
   input  mspc_pkg::word_type  pwdata,
   output mspc_pkg::word_type  prdata,
   output logic                pready
);
   import mspc_pkg::*;

`include "assert_macros.svh"

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_MDELTA = 16'h0002,
      S_SDIV   = 16'h0004,
      S_SPEED  = 16'h0008,
      S_ERR    = 16'h0010,
      S_IMUL   = 16'h0020,
      S_INTEG  = 16'h0040,
      S_FF     = 16'h0080,
      S_KP     = 16'h0100,
      S_KI     = 16'h0200,
      S_KD     = 16'h0400,
      S_KDMAG  = 16'h0800,
      S_DLOAD  = 16'h1000,
      S_DDIV   = 16'h2000,
      S_DADD   = 16'h4000,
      S_OUT    = 16'h8000
   } state_type;

   // Configuration registers.
   logic signed [23:0] target_ff, kp_ff, ki_ff, kd_ff, ffg_ff;
   logic [15:0]        ivl_ff;
   logic [15:0]        ivl_eff;

   // Sequencer and datapath registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   pulse_type          prev_cnt_ff, prev_cnt_in;
   pulse_type          delta_ff, delta_in;
   logic [DIV_W-1:0]   div_q_ff, div_q_in;
   logic [31:0]        div_r_ff, div_r_in;
   logic [31:0]        div_d_ff, div_d_in;
   logic               neg_ff, neg_in;
   logic signed [23:0] speed_ff, speed_in;
   logic signed [23:0] err_ff, err_in;
   logic signed [23:0] prev_err_ff, prev_err_in;
   logic signed [27:0] integ_ff, integ_in;
   logic signed [24:0] diff_ff, diff_in;
   logic signed [51:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [46:0]        pmag_ff, pmag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   duty_type           duty_ff, duty_in;
   speed_type          mspeed_ff, mspeed_in;

   // Shared multiplier and divider step.
   logic signed [23:0] mul_a;
   logic signed [27:0] mul_b;
   logic signed [51:0] mul_p;
   logic [32:0]        r_sh;
   logic [33:0]        r_sub;
   logic               fits;

   logic               accept, slot_free, glitch, rnd;
   pulse_type          delta_now;
   logic [10:0]        dmag;
   logic [56:0]        px, px1000;
   logic [35:0]        qmag;
   logic signed [24:0] esub;
   logic signed [40:0] isum;
   logic signed [31:0] duty_t;
   logic               cfg_wr;

   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;
   assign ivl_eff   = (ivl_ff == 16'd0) ? 16'd1 : ivl_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_duty     = duty_ff;
   assign rsp_measured_speed = mspeed_ff;

   always_comb begin
      unique case (paddr[4:2])
         REG_TARGET:   prdata = {8'd0, target_ff};
         REG_KP:       prdata = {8'd0, kp_ff};
         REG_KI:       prdata = {8'd0, ki_ff};
         REG_KD:       prdata = {8'd0, kd_ff};
         REG_FF:       prdata = {8'd0, ffg_ff};
         REG_INTERVAL: prdata = {16'd0, ivl_ff};
         default:      prdata = 32'd0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // One restoring division step per cycle.
   assign r_sh  = {div_r_ff, div_q_ff[DIV_W-1]};
   assign r_sub = {1'b0, r_sh} - {2'b00, div_d_ff};
   assign fits  = !r_sub[33];

   assign delta_now = req_pulse_count - prev_cnt_ff;
   assign glitch    = (delta_now > 32'sd1000) || (delta_now < -32'sd1000);
   assign dmag      = delta_ff[31] ? 11'(-delta_ff) : delta_ff[10:0];
   assign qmag      = div_q_ff[SPD_STEPS-1:0];
   assign esub      = 25'(target_ff) - 25'(speed_ff);
   assign isum      = 41'(integ_ff) + 41'(signed'(prod_ff[39:0]));
   assign px        = {10'd0, pmag_ff};
   assign px1000    = (px << 10) - (px << 4) - (px << 3);
   assign rnd       = acc_ff[63] && (acc_ff[31:0] != 32'd0);
   assign duty_t    = acc_ff[63:32] + {31'd0, rnd};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      prev_cnt_in  = prev_cnt_ff;
      delta_in     = delta_ff;
      div_q_in     = div_q_ff;
      div_r_in     = div_r_ff;
      div_d_in     = div_d_ff;
      neg_in       = neg_ff;
      speed_in     = speed_ff;
      err_in       = err_ff;
      prev_err_in  = prev_err_ff;
      integ_in     = integ_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      pmag_in      = pmag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      duty_in      = duty_ff;
      mspeed_in    = mspeed_ff;
      mul_a        = 24'sd0;
      mul_b        = 28'sd0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               prev_cnt_in = req_pulse_count;
               delta_in    = delta_now;
               if (!glitch) begin
                  state_in = S_MDELTA;
               end
            end
         end
         S_MDELTA: begin
            div_q_in = {36'(dmag) * 36'(SPEED_SCALE), {(DIV_W-SPD_STEPS){1'b0}}};
            div_r_in = 32'd0;
            div_d_in = {16'd0, PULSES_PER_REV} * {16'd0, ivl_eff};
            neg_in   = delta_ff[31];
            cnt_in   = CNT_W'(SPD_STEPS);
            state_in = S_SDIV;
         end
         S_SDIV, S_DDIV: begin
            div_r_in = fits ? r_sub[31:0] : r_sh[31:0];
            div_q_in = {div_q_ff[DIV_W-2:0], fits};
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = (state_ff == S_SDIV) ? S_SPEED : S_DADD;
            end
         end
         S_SPEED: begin
            if (!neg_ff) begin
               speed_in = (qmag > 36'd8388607) ? 24'sh7FFFFF : signed'(qmag[23:0]);
            end else begin
               speed_in = (qmag > 36'd8388608) ? -24'sh800000
                                               : signed'(24'(-qmag[23:0]));
            end
            state_in = S_ERR;
         end
         S_ERR: begin
            if (esub > 25'sd8388607) begin
               err_in = 24'sh7FFFFF;
            end else if (esub < -25'sd8388608) begin
               err_in = -24'sh800000;
            end else begin
               err_in = esub[23:0];
            end
            state_in = S_IMUL;
         end
         S_IMUL: begin
            mul_a    = err_ff;
            mul_b    = signed'({12'd0, ivl_eff});
            prod_in  = mul_p;
            state_in = S_INTEG;
         end
         S_INTEG: begin
            if (isum > 41'(INTEG_LIMIT)) begin
               integ_in = 28'(INTEG_LIMIT);
            end else if (isum < -41'(INTEG_LIMIT)) begin
               integ_in = -28'(INTEG_LIMIT);
            end else begin
               integ_in = isum[27:0];
            end
            diff_in  = 25'(err_ff) - 25'(prev_err_ff);
            state_in = S_FF;
         end
         S_FF: begin
            mul_a    = ffg_ff;
            mul_b    = 28'(target_ff);
            prod_in  = mul_p;
            state_in = S_KP;
         end
         S_KP: begin
            acc_in   = 64'(prod_ff);
            mul_a    = kp_ff;
            mul_b    = 28'(err_ff);
            prod_in  = mul_p;
            state_in = S_KI;
         end
         S_KI: begin
            acc_in   = acc_ff + 64'(prod_ff);
            mul_a    = ki_ff;
            mul_b    = integ_ff;
            prod_in  = mul_p;
            state_in = S_KD;
         end
         S_KD: begin
            acc_in   = acc_ff + 64'(prod_ff);
            mul_a    = kd_ff;
            mul_b    = 28'(diff_ff);
            prod_in  = mul_p;
            state_in = S_KDMAG;
         end
         S_KDMAG: begin
            neg_in   = prod_ff[51];
            pmag_in  = 47'(prod_ff[51] ? -prod_ff : prod_ff);
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            div_q_in = {px1000, {(DIV_W-DERIV_STEPS){1'b0}}};
            div_r_in = 32'd0;
            div_d_in = {16'd0, ivl_eff};
            cnt_in   = CNT_W'(DERIV_STEPS);
            state_in = S_DDIV;
         end
         S_DADD: begin
            acc_in   = neg_ff ? acc_ff - signed'(div_q_ff) : acc_ff + signed'(div_q_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               mspeed_in    = speed_ff;
               prev_err_in  = err_ff;
               if (duty_t > -32'sd30 && duty_t < 32'sd30) begin
                  duty_in = 9'sd0;
               end else if (duty_t > 32'sd255) begin
                  duty_in = 9'sd255;
               end else if (duty_t < -32'sd255) begin
                  duty_in = -9'sd255;
               end else begin
                  duty_in = duty_t[8:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         prev_cnt_ff  <= '0;
         prev_err_ff  <= '0;
         integ_ff     <= '0;
         target_ff    <= '0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         ffg_ff       <= '0;
         ivl_ff       <= INTERVAL_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_cnt_ff  <= prev_cnt_in;
         prev_err_ff  <= prev_err_in;
         integ_ff     <= integ_in;
         if (cfg_wr) begin
            unique case (paddr[4:2])
               REG_TARGET:   target_ff <= pwdata[23:0];
               REG_KP:       kp_ff     <= pwdata[23:0];
               REG_KI:       ki_ff     <= pwdata[23:0];
               REG_KD:       kd_ff     <= pwdata[23:0];
               REG_FF:       ffg_ff    <= pwdata[23:0];
               REG_INTERVAL: ivl_ff    <= pwdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      delta_ff  <= delta_in;
      div_q_ff  <= div_q_in;
      div_r_ff  <= div_r_in;
      div_d_ff  <= div_d_in;
      neg_ff    <= neg_in;
      speed_ff  <= speed_in;
      err_ff    <= err_in;
      diff_ff   <= diff_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      pmag_ff   <= pmag_in;
      duty_ff   <= duty_in;
      mspeed_ff <= mspeed_in;
   end

   `ASSERT_IMPLY(a_div_cnt, clock, reset, (state_ff == S_SDIV || state_ff == S_DDIV), (cnt_ff != '0), "divider running with zero count")
   `ASSERT_NEXT(a_out_loads, clock, reset, (state_ff == S_OUT && slot_free), (rsp_valid_ff && state_ff == S_IDLE), "finished tick not presented")
   `ASSERT_IMPLY(a_integ_lim, clock, reset, 1'b1, (integ_ff <= 28'(INTEG_LIMIT) && integ_ff >= -28'(INTEG_LIMIT)), "integral outside its clamp")
   `ASSERT_NEXT(a_glitch_idle, clock, reset, (accept && glitch), (state_ff == S_IDLE && prev_cnt_ff == $past(req_pulse_count)), "glitch tick not dropped")

endmodule

[dv/tb.sv]
// Self-checking testbench for the motor speed PID controller.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mspc_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   pulse_type           req_pulse_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   duty_type            rsp_drive_duty;
   speed_type           rsp_measured_speed;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   paddr_type           paddr = '0;
   word_type            pwdata = '0;
   word_type            prdata;
   logic                pready;

   motor_speed_pid_controller u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_pulse_count(req_pulse_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_drive_duty(rsp_drive_duty), .rsp_measured_speed(rsp_measured_speed),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // The clock runs at 100 MHz.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      duty_type  duty;
      speed_type speed;
   } control_out_t;

   // Local copy of the control registers and the loop state.
   logic signed [23:0] m_target, m_kp, m_ki, m_kd, m_ff;
   logic [15:0]        m_interval;
   logic [31:0]        m_prev_count;
   longint             m_prev_error, m_integral;

   pulse_type    tick_queue[$];
   control_out_t expected_outputs[$];
   int           mismatches = 0;
   int           outstanding = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Advances the local loop by one tick and queues the response it causes,
   // unless the pulse delta is a glitch.
   function automatic void predict_tick(pulse_type count);
      logic [31:0] diff;
      longint delta, ivl, speed, err, sum, duty;
      control_out_t r;
      diff  = count - m_prev_count;
      delta = longint'($signed(diff));
      ivl   = (m_interval == 0) ? 1 : longint'(m_interval);
      m_prev_count = count;
      if (delta > GLITCH_LIMIT || delta < -GLITCH_LIMIT) return;
      speed = clip((delta * 1000 * 65536) / (longint'(PULSES_PER_REV) * ivl),
                   -8388608, 8388607);
      err   = clip(longint'(m_target) - speed, -8388608, 8388607);
      m_integral = clip(m_integral + err * ivl, -INTEG_LIMIT, INTEG_LIMIT);
      sum = longint'(m_ff) * m_target + longint'(m_kp) * err + longint'(m_ki) * m_integral
          + (longint'(m_kd) * (err - m_prev_error) * 1000) / ivl;
      duty = sum / 64'sd4294967296;
      if (duty > -DEADBAND && duty < DEADBAND) duty = 0;
      duty = clip(duty, -DUTY_MAX, DUTY_MAX);
      m_prev_error = err;
      r.duty  = duty_type'(duty);
      r.speed = speed_type'(speed);
      expected_outputs.push_back(r);
   endfunction

   // Request driver: a random gap is drawn after each taken request before the next one.
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         predict_tick(req_pulse_count);
         outstanding = outstanding - 1;
         req_gap = $urandom_range(0, 6);
         if (req_gap == 0 && tick_queue.size() > 0) begin
            req_pulse_count <= tick_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid && tick_queue.size() > 0) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
         end else begin
            req_valid <= 1'b1;
            req_pulse_count <= tick_queue.pop_front();
         end
      end
   end

   // Response monitor with a random stall drawn per response.
   int rsp_hold = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: response with none expected: duty %0d speed %0d",
                           rsp_drive_duty, rsp_measured_speed);
            end else begin
               control_out_t e;
               e = expected_outputs.pop_front();
               if (e.duty !== rsp_drive_duty || e.speed !== rsp_measured_speed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: expected duty %0d speed %0d, got duty %0d speed %0d",
                              e.duty, e.speed, rsp_drive_duty, rsp_measured_speed);
               end
            end
            rsp_hold = $urandom_range(0, 6);
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold = rsp_hold - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One APB write, setup then access; the local register copy follows it.
   task automatic write_reg(logic [2:0] index, word_type value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= paddr_type'({index, 2'b00}); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (index)
         REG_TARGET:   m_target   = value[23:0];
         REG_KP:       m_kp       = value[23:0];
         REG_KI:       m_ki       = value[23:0];
         REG_KD:       m_kd       = value[23:0];
         REG_FF:       m_ff       = value[23:0];
         REG_INTERVAL: m_interval = value[15:0];
         default: ;
      endcase
   endtask

   // Hands a batch of ticks to the driver and waits until the block is idle.
   task automatic run_ticks(pulse_type counts[$]);
      foreach (counts[i]) tick_queue.push_back(counts[i]);
      outstanding = outstanding + counts.size();
      while (outstanding > 0 || expected_outputs.size() > 0) @(posedge clock);
      // A glitch tick gives no response, so let the last tick finish.
      repeat (200) @(posedge clock);
   endtask

   // Small deltas mostly, with occasional glitches and counter wraps.
   function automatic pulse_type next_count(pulse_type last);
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return pulse_type'($urandom());
      if (sel == 1) return last + pulse_type'($urandom_range(1001, 5000));
      if (sel == 2) return last + (($urandom_range(0, 1)) ? 1000 : -1000);
      return last + pulse_type'($urandom_range(0, 2000)) - 1000;
   endfunction

   function automatic word_type rand_gain();
      int sel;
      sel = $urandom_range(0, 5);
      if (sel == 0) return 32'h007FFFFF;
      if (sel == 1) return 32'h00800000;
      if (sel == 2) return $urandom();
      return word_type'(24'($signed($urandom_range(0, 2097152)) - 1048576));
   endfunction

   initial begin
      pulse_type batch[$];
      pulse_type last;
      m_target = 0; m_kp = 0; m_ki = 0; m_kd = 0; m_ff = 0;
      m_interval = INTERVAL_RESET;
      m_prev_count = 0; m_prev_error = 0; m_integral = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: glitch edges, counter wrap and extremes under default registers.
      batch = '{1000, 0, -1000, -2001, -1001, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh80000000 + 1000, 0, 500};
      run_ticks(batch);

      // Strong gains with a long interval drive the duty into the clamp.
      write_reg(REG_TARGET, 32'h007FFFFF);
      write_reg(REG_KP, 32'h00010000);
      write_reg(REG_KI, 32'h007FFFFF);
      write_reg(REG_KD, 32'h00800000);
      write_reg(REG_FF, 32'h00800000);
      write_reg(REG_INTERVAL, 32'h0000FFFF);
      batch = '{1500, 2500, 1500, 1500, 2000, 1000};
      run_ticks(batch);

      // A zero interval is used as one.
      write_reg(REG_INTERVAL, 32'h0);
      write_reg(REG_TARGET, 32'h00800000);
      batch = '{2000, 1000, 1001, 1001, 1};
      run_ticks(batch);
      write_reg(REG_INTERVAL, 32'h1);
      batch = '{1000, 0, 3};
      run_ticks(batch);

      // Random phases, each with fresh registers.
      last = 3;
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(REG_TARGET, rand_gain());
         write_reg(REG_KP, rand_gain());
         write_reg(REG_KI, rand_gain());
         write_reg(REG_KD, rand_gain());
         write_reg(REG_FF, rand_gain());
         case ($urandom_range(0, 3))
            0: write_reg(REG_INTERVAL, $urandom());
            1: write_reg(REG_INTERVAL, $urandom_range(1, 5));
            default: write_reg(REG_INTERVAL, $urandom_range(1, 100));
         endcase
         batch.delete();
         for (int i = 0; i < 50; i++) begin
            last = next_count(last);
            batch.push_back(last);
         end
         run_ticks(batch);
      end

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mspc_pkg.sv
hw/rtl/motor_speed_pid_controller.sv
dv/tb.sv
